>>> hw/rtl/bcgs_pkg.sv
// Package for the bilinear category grid sampler: shared types and constants.
// No dependencies.
`default_nettype none
package bcgs_pkg;
    typedef enum logic [1:0] {
        REG_RECIP_W = 2'd0,
        REG_RECIP_H = 2'd1,
        REG_COLS    = 2'd2,
        REG_ROWS    = 2'd3
    } t_reg_idx;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [46:0] HALF_Q47 = 47'h4000_0000_0000;
    localparam logic [16:0] ONE_Q16  = 17'h10000;

    typedef struct packed {
        logic [2:0]  cat;
        logic [15:0] lvl;
    } t_node;
endpackage
`default_nettype wire

>>> hw/rtl/bcgs_div.sv
// Pipelined restoring divider: 50-bit dividend by 33-bit divisor, 17-bit quotient.
// Uses no package items; one quotient bit per stage.
`default_nettype none
module bcgs_div #(
    parameter int TAG_W = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [49:0]      i_num,
    input  wire logic [32:0]      i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [16:0]           o_quot,
    output logic [TAG_W-1:0]      o_tag
);
    localparam int STEPS = 17;

    logic [STEPS:0]            r_v;
    logic [49:0]               r_rem [STEPS+1];
    logic [32:0]               r_den [STEPS+1];
    logic [16:0]               r_q   [STEPS+1];
    logic [TAG_W-1:0]          r_tag [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_tag[0] <= i_tag;
            for (int s = 0; s < STEPS; s++) begin
                if ({17'd0, r_rem[s]} >= ({34'd0, r_den[s]} << (STEPS - 1 - s))) begin
                    r_rem[s+1] <= 50'(({17'd0, r_rem[s]}
                                  - ({34'd0, r_den[s]} << (STEPS - 1 - s))));
                    r_q[s+1]   <= r_q[s] | (17'd1 << (STEPS - 1 - s));
                end else begin
                    r_rem[s+1] <= r_rem[s];
                    r_q[s+1]   <= r_q[s];
                end
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_quot  = r_q[STEPS];
    assign o_tag   = r_tag[STEPS];

    logic unused;
    assign unused = ^{r_rem[STEPS], r_den[STEPS]};
endmodule
`default_nettype wire

>>> hw/rtl/bilinear_category_grid_sampler_core.sv
// Bilinear category grid sampler. Write words load grid nodes (no result). A write word
// that follows a sample word is held until that sample has read its four corners. Sample
// words inside the grid yield one to four result words, one per distinct corner category;
// a sample outside the grid yields a single result word flagged outside. Sample words are
// spaced by an issue gap counter so the single node memory read port serves the four corners in turn.
// The pipeline then streams through a 17-stage divider.
// Depends on bcgs_pkg and bcgs_div.
`default_nettype none
module bilinear_category_grid_sampler_core #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic [5:0]  i_node_col,
    input  wire logic [5:0]  i_node_row,
    input  wire logic [2:0]  i_node_category,
    input  wire logic [15:0] i_node_level,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_category,
    output logic [15:0]      o_blended_level,
    output logic [16:0]      o_weight_sum,
    output logic             o_outside,
    output logic             o_last
);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = $clog2(MAX_COLUMNS + 1) > $clog2(MAX_ROWS + 1) ?
                           $clog2(MAX_COLUMNS + 1) : $clog2(MAX_ROWS + 1);

    // configuration
    logic [31:0] r_rw, r_rh;
    logic [6:0]  r_cols, r_rows;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw <= 32'h8000_0000; r_rh <= 32'h8000_0000;
            r_cols <= 7'd64; r_rows <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (bcgs_pkg::t_reg_idx'(i_cfg_idx))
                bcgs_pkg::REG_RECIP_W: r_rw   <= i_cfg_data;
                bcgs_pkg::REG_RECIP_H: r_rh   <= i_cfg_data;
                bcgs_pkg::REG_COLS:    r_cols <= i_cfg_data[6:0];
                bcgs_pkg::REG_ROWS:    r_rows <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    function automatic logic [SW-1:0] sat(input logic [6:0] v, input int mx);
        logic [SW-1:0] r;
        if (v < 7'd2) r = SW'(2);
        else if (32'(v) > mx) r = SW'(mx);
        else r = SW'(v);
        return r;
    endfunction

    // global stall: pipeline advances when the output register can take data
    logic en;
    logic r_ov;
    assign en = !r_ov || i_ready;

    // Stage A: magnitudes times reciprocals
    logic        a_v;
    logic        a_nx, a_ny;
    logic [63:0] a_mx, a_my;
    logic [31:0] magx, magy;
    assign magx = i_pos_x[31] ? 32'(-i_pos_x) : i_pos_x;
    assign magy = i_pos_y[31] ? 32'(-i_pos_y) : i_pos_y;

    // sample issue gating: after each accepted sample a gap counter must run down
    logic [1:0] r_gap;
    logic       smp_ok;
    assign smp_ok  = (r_gap == 2'd0);

    logic acc_smp;
    assign acc_smp = i_valid && o_ready && i_operation == bcgs_pkg::OP_SAMPLE;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gap <= '0;
        else if (en) begin
            if (acc_smp) r_gap <= 2'd3;
            else if (r_gap != 2'd0) r_gap <= r_gap - 2'd1;
        end
    end

    // node memory
    bcgs_pkg::t_node r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_operation == bcgs_pkg::OP_WRITE &&
            32'(i_node_col) < MAX_COLUMNS && 32'(i_node_row) < MAX_ROWS)
            r_mem[AW'({RW'(i_node_row), CW'(i_node_col)})] <=
                '{cat: i_node_category, lvl: i_node_level};
    end

    logic r_a_v, r_a_nx, r_a_ny;
    logic [63:0] r_a_mx, r_a_my;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en) r_a_v <= acc_smp;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_nx <= i_pos_x[31]; r_a_ny <= i_pos_y[31];
            r_a_mx <= 64'(magx) * 64'(r_rw);
            r_a_my <= 64'(magy) * 64'(r_rh);
        end
    end
    assign a_v = r_a_v; assign a_nx = r_a_nx; assign a_ny = r_a_ny;
    assign a_mx = r_a_mx; assign a_my = r_a_my;

    // Stage B: normalize and outside test
    logic r_b_v, r_b_out;
    logic [47:0] r_b_nx, r_b_ny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (en) r_b_v <= a_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_out <= (a_mx > 64'(bcgs_pkg::HALF_Q47)) || (a_my > 64'(bcgs_pkg::HALF_Q47));
            r_b_nx <= a_nx ? 48'(64'(bcgs_pkg::HALF_Q47) - a_mx)
                           : 48'(64'(bcgs_pkg::HALF_Q47) + a_mx);
            r_b_ny <= a_ny ? 48'(64'(bcgs_pkg::HALF_Q47) - a_my)
                           : 48'(64'(bcgs_pkg::HALF_Q47) + a_my);
        end
    end

    // Stage C: scale by size-1, corners and fractions
    logic [SW-1:0] cols, rows, cm1, rm1;
    assign cols = sat(r_cols, MAX_COLUMNS);
    assign rows = sat(r_rows, MAX_ROWS);
    assign cm1 = cols - SW'(1);
    assign rm1 = rows - SW'(1);
    logic [47+SW:0] xi, yi;
    assign xi = (47+SW+1)'(r_b_nx) * (47+SW+1)'(cm1);
    assign yi = (47+SW+1)'(r_b_ny) * (47+SW+1)'(rm1);

    logic r_c_v, r_c_out;
    logic [SW-1:0] r_c_x0, r_c_y0;
    logic [15:0] r_c_fx, r_c_fy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (en) r_c_v <= r_b_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_out <= r_b_out;
            r_c_x0  <= (xi[47+SW:47] > (SW+1)'(cm1)) ? cm1 : SW'(xi[47+SW:47]);
            r_c_y0  <= (yi[47+SW:47] > (SW+1)'(rm1)) ? rm1 : SW'(yi[47+SW:47]);
            r_c_fx  <= xi[46:31];
            r_c_fy  <= yi[46:31];
        end
    end

    // Stage D: far corners and weights; hold for corner sweep
    logic r_d_v, r_d_out;
    logic [SW-1:0] r_d_x0, r_d_x1, r_d_y0, r_d_y1;
    logic [32:0] r_d_w [4];
    logic [16:0] gx, gy;
    assign gx = bcgs_pkg::ONE_Q16 - 17'(r_c_fx);
    assign gy = bcgs_pkg::ONE_Q16 - 17'(r_c_fy);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else if (en) r_d_v <= r_c_v;
    end
    always_ff @(posedge i_clk) begin
        if (en && r_c_v) begin
            r_d_out <= r_c_out;
            r_d_x0 <= r_c_x0; r_d_y0 <= r_c_y0;
            r_d_x1 <= (r_c_x0 + SW'(1) < cm1) ? r_c_x0 + SW'(1) : cm1;
            r_d_y1 <= (r_c_y0 + SW'(1) < rm1) ? r_c_y0 + SW'(1) : rm1;
            r_d_w[0] <= 33'(34'(gx) * 34'(gy));
            r_d_w[1] <= 33'(34'(r_c_fx) * 34'(gy));
            r_d_w[2] <= 33'(34'(gx) * 34'(r_c_fy));
            r_d_w[3] <= 33'(34'(r_c_fx) * 34'(r_c_fy));
        end
    end

    // Stage E: corner sweep, one memory read per cycle while the pipeline is not stalled
    logic       r_e_act;
    logic [1:0] r_e_k;
    logic       r_e_out;
    logic [SW-1:0] r_e_x0, r_e_x1, r_e_y0, r_e_y1;
    logic [32:0] r_e_w [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_act <= 1'b0; r_e_k <= '0;
        end else if (en) begin
            if (r_d_v) begin
                r_e_act <= 1'b1; r_e_k <= 2'd0;
            end else if (r_e_act) begin
                r_e_k <= r_e_k + 2'd1;
                if (r_e_k == 2'd3) r_e_act <= 1'b0;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (en && r_d_v) begin
            r_e_out <= r_d_out;
            r_e_x0 <= r_d_x0; r_e_x1 <= r_d_x1;
            r_e_y0 <= r_d_y0; r_e_y1 <= r_d_y1;
            r_e_w <= r_d_w;
        end
    end
    logic [SW-1:0] ex, ey;
    assign ex = r_e_k[0] ? r_e_x1 : r_e_x0;
    assign ey = r_e_k[1] ? r_e_y1 : r_e_y0;

    // hold writes until every earlier sample has read its corners
    logic smp_rd_pend;
    assign smp_rd_pend = r_a_v || r_b_v || r_c_v || r_d_v || r_e_act;
    assign o_ready = en && (i_operation == bcgs_pkg::OP_WRITE ? !smp_rd_pend : smp_ok);

    // Stage F: registered read
    bcgs_pkg::t_node r_f_node;
    logic r_f_v, r_f_out;
    logic [1:0] r_f_k;
    logic [32:0] r_f_w;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_v <= 1'b0;
        else if (en) r_f_v <= r_e_act;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_node <= r_mem[AW'({RW'(ey), CW'(ex)})];
            r_f_out  <= r_e_out;
            r_f_k    <= r_e_k;
            r_f_w    <= r_e_w[r_e_k];
        end
    end

    // Stage G: group merge over corners (accumulate in order)
    logic [2:0]  r_g_cat [4];
    logic [32:0] r_g_w   [4];
    logic [48:0] r_g_wh  [4];
    logic [15:0] r_g_h   [4];
    logic [2:0]  r_g_n;
    logic        r_g_out;
    logic        r_g_done;
    logic [1:0]  hit;
    logic        found;
    always_comb begin
        found = 1'b0; hit = 2'(r_g_n);
        for (int g = 3; g >= 0; g--) begin
            if (3'(g) < r_g_n && r_g_cat[g] == r_f_node.cat) begin
                found = 1'b1; hit = 2'(g);
            end
        end
    end
    logic [2:0] g_n0;
    assign g_n0 = (r_f_k == 2'd0) ? 3'd0 : r_g_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_done <= 1'b0;
        else if (en) r_g_done <= r_f_v && r_f_k == 2'd3;
    end
    logic [48:0] prod;
    assign prod = 49'(r_f_w) * 49'(r_f_node.lvl);
    always_ff @(posedge i_clk) begin
        if (en && r_f_v) begin
            r_g_out <= r_f_out;
            if (r_f_k == 2'd0) begin
                r_g_n <= 3'd1;
                r_g_cat[0] <= r_f_node.cat; r_g_w[0] <= r_f_w;
                r_g_wh[0] <= prod; r_g_h[0] <= r_f_node.lvl;
            end else if (found) begin
                r_g_w[hit]  <= r_g_w[hit] + r_f_w;
                r_g_wh[hit] <= r_g_wh[hit] + prod;
            end else begin
                r_g_n <= g_n0 + 3'd1;
                r_g_cat[hit] <= r_f_node.cat; r_g_w[hit] <= r_f_w;
                r_g_wh[hit] <= prod; r_g_h[hit] <= r_f_node.lvl;
            end
        end
    end

    // Stage H: emit groups one per cycle into the divider while the pipeline is not stalled
    logic       r_h_act;
    logic [1:0] r_h_g;
    logic [2:0] r_h_n;
    logic       r_h_out;
    logic [2:0]  r_h_cat [4];
    logic [32:0] r_h_w   [4];
    logic [48:0] r_h_wh  [4];
    logic [15:0] r_h_h   [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_act <= 1'b0; r_h_g <= '0;
        end else if (en) begin
            if (r_g_done) begin
                r_h_act <= 1'b1; r_h_g <= '0;
            end else if (r_h_act) begin
                r_h_g <= r_h_g + 2'd1;
                if (3'(r_h_g) + 3'd1 >= r_h_n || r_h_out) r_h_act <= 1'b0;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (en && r_g_done) begin
            r_h_n <= r_g_n; r_h_out <= r_g_out;
            r_h_cat <= r_g_cat; r_h_w <= r_g_w; r_h_wh <= r_g_wh; r_h_h <= r_g_h;
        end
    end

    logic [32:0] hw;
    logic        hlast;
    assign hw    = r_h_w[r_h_g];
    assign hlast = r_h_out || (3'(r_h_g) + 3'd1 >= r_h_n);

    // tag: cat(3) out(1) last(1) zero(1) first_h(16) ws(17)
    localparam int TW = 39;
    logic [TW-1:0] tag_in, tag_out;
    logic [16:0]   ws;
    assign ws = (hw[32:16] > bcgs_pkg::ONE_Q16) ? bcgs_pkg::ONE_Q16 : hw[32:16];
    assign tag_in = {r_h_out ? 3'd0 : r_h_cat[r_h_g], r_h_out, hlast, hw == 33'd0,
                     r_h_h[r_h_g], r_h_out ? 17'd0 : ws};
    logic [49:0] num;
    assign num = 50'(r_h_wh[r_h_g]) + 50'(hw >> 1);

    logic        dv;
    logic [16:0] dq;
    bcgs_div #(.TAG_W(TW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_act),
        .i_num   (num),
        .i_den   (hw == 33'd0 ? 33'd1 : hw),
        .i_tag   (tag_in),
        .o_valid (dv),
        .o_quot  (dq),
        .o_tag   (tag_out)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= dv;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_category   <= tag_out[38:36];
            o_outside    <= tag_out[35];
            o_last       <= tag_out[34];
            o_weight_sum <= tag_out[16:0];
            if (tag_out[35]) o_blended_level <= '0;
            else if (tag_out[33]) o_blended_level <= tag_out[32:17];
            else o_blended_level <= (dq > 17'hFFFF) ? 16'hFFFF : dq[15:0];
        end
    end
    assign o_valid = r_ov;
endmodule
`default_nettype wire

>>> bench/tb.sv
// Testbench for bilinear_category_grid_sampler_core: a behavioral grid model
// predicts every result word and a checker compares them in order.
// Depends on bcgs_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    typedef longint unsigned u64;
    typedef struct {
        logic [2:0]  cat;
        logic [15:0] lvl;
        logic [16:0] ws;
        logic        outside;
        logic        last;
    } t_result;

    localparam int  NCOL       = 64;
    localparam int  NROW       = 64;
    localparam int  NFILL      = 8;
    localparam int  LIMIT      = 600000;
    localparam int  DRAIN      = 60;
    localparam u64  HALF       = u64'(1) << 46;
    localparam u64  FRAC_MASK  = (u64'(1) << 47) - 1;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_operation = 0;
    logic [5:0]  i_node_col = 0;
    logic [5:0]  i_node_row = 0;
    logic [2:0]  i_node_category = 0;
    logic [15:0] i_node_level = 0;
    logic signed [31:0] i_pos_x = 0;
    logic signed [31:0] i_pos_y = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_category;
    logic [15:0] o_blended_level;
    logic [16:0] o_weight_sum;
    logic        o_outside;
    logic        o_last;

    bilinear_category_grid_sampler_core i_dut (.*);

    bcgs_pkg::t_node grid_model [NCOL*NROW];
    u64      recip_x = 64'h8000_0000, recip_y = 64'h8000_0000;
    u64      cols_reg = 64, rows_reg = 64;
    t_result pending_results [$];
    int      errors = 0;
    int      cycles = 0;
    int      idle_pct = 0, stall_pct = 0;
    int      hold_left = 0;
    bit      hold_start = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left = 400;
            hold_start = 0;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word cat=%0d", o_category);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_category !== exp_r.cat || o_blended_level !== exp_r.lvl ||
                    o_weight_sum !== exp_r.ws || o_outside !== exp_r.outside ||
                    o_last !== exp_r.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp cat=%0d lvl=%0d ws=%0d out=%0b last=%0b",
                                  " act cat=%0d lvl=%0d ws=%0d out=%0b last=%0b"},
                                 exp_r.cat, exp_r.lvl, exp_r.ws, exp_r.outside, exp_r.last,
                                 o_category, o_blended_level, o_weight_sum, o_outside,
                                 o_last);
                end
            end
        end
    end

    function automatic bit normalize_axis(input logic [31:0] p, input u64 recip,
                                          output u64 n);
        u64 mag;
        u64 m;
        mag = p[31] ? u64'(32'(-p)) : u64'(p);
        m = mag * recip;
        n = p[31] ? HALF - m : HALF + m;
        return m <= HALF;
    endfunction

    function automatic u64 clamp_size(input u64 v, input u64 maxv);
        return (v < 2) ? 2 : (v > maxv) ? maxv : v;
    endfunction

    function automatic void locate_axis(input u64 n, input u64 size, output u64 i0,
                                        output u64 i1, output u64 frac);
        u64 xi;
        xi = n * (size - 1);
        i0 = xi >> 47;
        if (i0 > size - 1) i0 = size - 1;
        i1 = (i0 + 1 < size - 1) ? i0 + 1 : size - 1;
        frac = (xi & FRAC_MASK) >> 31;
    endfunction

    task automatic predict_sample(input logic [31:0] px, input logic [31:0] py);
        u64 nx, ny, x0, x1, fx, y0, y1, fy, lvl, ws;
        u64 cx[4], cy[4], wt[4], g_w[4], g_wh[4], g_first[4];
        logic [2:0] g_cat[4];
        bcgs_pkg::t_node nd;
        t_result r;
        int groups, g;
        bit in_x, in_y;
        in_x = normalize_axis(px, recip_x, nx);
        in_y = normalize_axis(py, recip_y, ny);
        if (!in_x || !in_y) begin
            r = '{cat: 0, lvl: 0, ws: 0, outside: 1, last: 1};
            pending_results.push_back(r);
            return;
        end
        locate_axis(nx, clamp_size(cols_reg, NCOL), x0, x1, fx);
        locate_axis(ny, clamp_size(rows_reg, NROW), y0, y1, fy);
        cx = '{x0, x1, x0, x1};
        cy = '{y0, y0, y1, y1};
        wt = '{(65536 - fx) * (65536 - fy), fx * (65536 - fy), (65536 - fx) * fy, fx * fy};
        groups = 0;
        for (int k = 0; k < 4; k++) begin
            nd = grid_model[cy[k] * NCOL + cx[k]];
            g = 0;
            while (g < groups && g_cat[g] != nd.cat) g++;
            if (g == groups) begin
                g_cat[g] = nd.cat;
                g_w[g] = 0;
                g_wh[g] = 0;
                g_first[g] = nd.lvl;
                groups++;
            end
            g_w[g] += wt[k];
            g_wh[g] += wt[k] * nd.lvl;
        end
        for (int j = 0; j < groups; j++) begin
            lvl = g_first[j];
            if (g_w[j] != 0) lvl = (g_wh[j] + g_w[j] / 2) / g_w[j];
            if (lvl > 65535) lvl = 65535;
            ws = g_w[j] >> 16;
            if (ws > 65536) ws = 65536;
            r = '{cat: g_cat[j], lvl: lvl[15:0], ws: ws[16:0], outside: 0,
                  last: (j == groups - 1)};
            pending_results.push_back(r);
        end
    endtask

    task automatic send_word(input logic op, input logic [5:0] col, input logic [5:0] row,
                             input logic [2:0] cat, input logic [15:0] lvl,
                             input logic [31:0] px, input logic [31:0] py);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_node_col <= col;
        i_node_row <= row;
        i_node_category <= cat;
        i_node_level <= lvl;
        i_pos_x <= px;
        i_pos_y <= py;
        do @(posedge i_clk); while (!o_ready);
        if (op == bcgs_pkg::OP_WRITE) grid_model[row * NCOL + col] = '{cat: cat, lvl: lvl};
        else predict_sample(px, py);
    endtask

    task automatic write_node(input int col, input int row, input logic [2:0] cat,
                              input logic [15:0] lvl);
        send_word(bcgs_pkg::OP_WRITE, col[5:0], row[5:0], cat, lvl, $urandom, $urandom);
    endtask

    task automatic sample_at(input logic [31:0] px, input logic [31:0] py);
        send_word(bcgs_pkg::OP_SAMPLE, 6'($urandom), 6'($urandom), 3'($urandom),
                  16'($urandom), px, py);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_regs(input u64 rx, input u64 ry, input u64 nc, input u64 nr);
        u64 vals[4];
        bcgs_pkg::t_reg_idx idx[4];
        vals = '{rx, ry, nc, nr};
        idx = '{bcgs_pkg::REG_RECIP_W, bcgs_pkg::REG_RECIP_H, bcgs_pkg::REG_COLS,
                bcgs_pkg::REG_ROWS};
        wait_idle();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[k];
            i_cfg_data <= vals[k][31:0];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        recip_x = rx & 64'hFFFF_FFFF;
        recip_y = ry & 64'hFFFF_FFFF;
        cols_reg = nc & 64'h7F;
        rows_reg = nr & 64'h7F;
    endtask

    function automatic logic [31:0] inside_pos(input u64 recip);
        u64 span, mag;
        span = (recip == 0) ? 64'h8000_0000 : HALF / recip;
        if (span > 64'h8000_0000) span = 64'h8000_0000;
        case ($urandom_range(0, 9))
            0: mag = span;
            1: mag = 0;
            default: mag = $urandom_range(0, span[31:0]);
        endcase
        return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
    endfunction

    task automatic fill_grid();
        for (int r = 0; r < NFILL; r++)
            for (int c = 0; c < NFILL; c++)
                write_node(c, r, 3'($urandom), 16'($urandom));
    endtask

    task automatic test_position_edges();
        set_regs(64'h8000_0000, 64'h8000_0000, NFILL, NFILL);
        sample_at(32'h0, 32'h0);
        sample_at(32'h0000_8000, 32'hFFFF_8000);
        sample_at(32'h0000_8001, 32'h0);
        sample_at(32'h0, 32'hFFFF_7FFF);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'h7FFF_FFFF, 32'h0);
        set_regs(0, 0, NFILL, NFILL);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'hFFFF_FFFF, 32'h1234_5678);
    endtask

    task automatic test_category_merge();
        set_regs(64'h8000_0000, 64'h8000_0000, NFILL, NFILL);
        write_node(3, 3, 1, 16'h0000);
        write_node(4, 3, 2, 16'hFFFF);
        write_node(3, 4, 3, 16'h1234);
        write_node(4, 4, 4, 16'h8000);
        sample_at(0, 0);
        write_node(4, 4, 1, 16'hFFFF);
        write_node(3, 4, 2, 16'h0001);
        sample_at(0, 0);
        write_node(4, 3, 1, 16'h7777);
        write_node(3, 4, 1, 16'h0003);
        sample_at(0, 0);
        sample_at(32'hFFFF_8000, 32'hFFFF_8000);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'hFFFF_8000, 32'h0000_8000);
    endtask

    task automatic test_grid_saturation();
        set_regs(64'h8000_0000, 64'h4000_0000, 0, 127);
        write_node(0, 63, 5, 16'h4321);
        write_node(1, 63, 6, 16'hA5A5);
        sample_at(0, 32'hFFFF_0000);
        sample_at(32'h0000_8000, 32'h0001_0000);
        sample_at(32'h0000_8000, 32'hFFFF_3333);
        set_regs(64'h0000_0001, 64'h8000_0000, 1, 2);
        sample_at(32'h7FFF_FFFF, 32'h0000_4000);
        sample_at(32'h8000_0000, 32'hFFFF_C000);
    endtask

    task automatic test_random_traffic(input int count, input int ip, input int sp);
        int kind;
        idle_pct = ip;
        stall_pct = sp;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) write_node($urandom_range(0, NFILL - 1),
                                      $urandom_range(0, NFILL - 1),
                                      3'($urandom), 16'($urandom));
            else if (kind < 88) sample_at(inside_pos(recip_x), inside_pos(recip_y));
            else sample_at($urandom, $urandom);
        end
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_start = 1;
        for (int k = 0; k < 40; k++) sample_at(inside_pos(recip_x), inside_pos(recip_y));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fill_grid();
        test_position_edges();
        test_category_merge();
        test_grid_saturation();
        set_regs(64'h8000_0000, 64'h8000_0000, NFILL, NFILL);
        test_random_traffic(50, 0, 0);
        set_regs($urandom_range(0, 32'h8000_0000), $urandom_range(0, 32'h8000_0000),
                 $urandom_range(2, NFILL), $urandom_range(2, NFILL));
        test_random_traffic(50, 67, 0);
        set_regs(64'h0100_0000, 64'h8000_0000, $urandom_range(0, NFILL),
                 $urandom_range(0, NFILL));
        test_random_traffic(50, 0, 67);
        set_regs($urandom, $urandom, 2, NFILL);
        test_random_traffic(50, 19, 19);
        test_backpressure();
        wait_idle();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/bcgs_pkg.sv
hw/rtl/bcgs_div.sv
hw/rtl/bilinear_category_grid_sampler_core.sv
bench/tb.sv
